### design/wcc_pkg.sv
// shared types and constants of the weighted contingency counter
`default_nettype none

package wcc_pkg;

	localparam int ACT_W       = 3;
	localparam int DOM_W       = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 5;
	localparam int WEIGHT_W    = 16;
	localparam int RIDX_W      = 16;
	localparam int OUT_IDX_W   = 16;
	localparam int OUT_COUNT_W = 48;
	localparam int MAX_DIGITS  = 4;
	localparam int STRIDE_W    = 2 * DOM_W;
	localparam int PART_W      = 3 * DOM_W;
	localparam int IDX_W       = 4 * DOM_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(1);
	localparam logic [DOM_W-1:0] DOMAIN_RESET = DOM_W'(2);

	localparam logic REQ_COUNT = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_VARS = 3'd0,
		CFG_DOMAIN_A    = 3'd1,
		CFG_DOMAIN_B    = 3'd2,
		CFG_DOMAIN_C    = 3'd3,
		CFG_DOMAIN_D    = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DOMAIN = 2'd1,
		ST_RANGE  = 2'd2,
		ST_SAT    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		JOB_COUNT,
		JOB_READ,
		JOB_REPLY
	} job_op_t;

	typedef struct packed {
		job_op_t               op;
		logic [IDX_W-1:0]      index;
		logic [WEIGHT_W-1:0]   weight;
		status_t               status;
	} job_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_MODIFY
	} back_state_t;

endpackage

`default_nettype wire

### design/wcc_front.sv
// front end: config registers, request capture, index forming and classification
`default_nettype none

module wcc_front #(
	parameter int MAX_VARS    = 4,
	parameter int VALUE_BITS  = 4,
	parameter int TABLE_DEPTH = 65536
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [wcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wcc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             req_type,
	input  wire logic [VALUE_BITS-1:0]            value_a,
	input  wire logic [VALUE_BITS-1:0]            value_b,
	input  wire logic [VALUE_BITS-1:0]            value_c,
	input  wire logic [VALUE_BITS-1:0]            value_d,
	input  wire logic [wcc_pkg::WEIGHT_W-1:0]     row_weight,
	input  wire logic [wcc_pkg::RIDX_W-1:0]       read_index,
	input  wire logic                             hold,
	output logic                                  job_valid,
	input  wire logic                             job_ready,
	output wcc_pkg::job_t                         job
);
	import wcc_pkg::*;

	localparam int CMP_W   = (VALUE_BITS > DOM_W) ? VALUE_BITS : DOM_W;
	localparam int VAR_LIM = (MAX_VARS < MAX_DIGITS) ? MAX_VARS : MAX_DIGITS;
	localparam logic [ACT_W-1:0] VAR_LIM_L = ACT_W'(VAR_LIM);
	localparam logic [IDX_W:0]   DEPTH_L   = (IDX_W + 1)'(TABLE_DEPTH);

	// configuration
	logic [ACT_W-1:0]    active_q;
	logic [DOM_W-1:0]    dom_q [MAX_DIGITS];
	logic [STRIDE_W-1:0] stride_c_q;

	// pipeline
	logic                  valid_s1, valid_s2, valid_s3;
	logic                  type_s1, type_s2, type_s3;
	logic [VALUE_BITS-1:0] val_s1 [MAX_DIGITS];
	logic [WEIGHT_W-1:0]   weight_s1, weight_s2, weight_s3;
	logic [RIDX_W-1:0]     ridx_s1, ridx_s2, ridx_s3;
	logic                  bad_s2, bad_s3;
	logic [IDX_W-1:0]      pabc_s2;
	logic [PART_W-1:0]     pdx_s2;
	logic [IDX_W-1:0]      idx_s3;

	logic                  adv1, adv2, adv3, ld2, ld3, accept;
	logic [ACT_W-1:0]      used_n;
	logic [MAX_DIGITS-1:0] en_w;
	logic [DOM_W-1:0]      dig_w [MAX_DIGITS];
	logic                  bad_w;
	logic [STRIDE_W-1:0]   pb_w;
	logic [PART_W-1:0]     pc_w, pdx_w;
	logic [IDX_W-1:0]      pabc_w, idx_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= ACTIVE_RESET;
			for (int i = 0; i < MAX_DIGITS; i++) begin
				dom_q[i] <= DOMAIN_RESET;
			end
			stride_c_q <= STRIDE_W'(DOMAIN_RESET) * STRIDE_W'(DOMAIN_RESET);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACTIVE_VARS: active_q <= cfg_data[ACT_W-1:0];
					CFG_DOMAIN_A:    dom_q[0] <= cfg_data[DOM_W-1:0];
					CFG_DOMAIN_B:    dom_q[1] <= cfg_data[DOM_W-1:0];
					CFG_DOMAIN_C:    dom_q[2] <= cfg_data[DOM_W-1:0];
					CFG_DOMAIN_D:    dom_q[3] <= cfg_data[DOM_W-1:0];
					default: ;
				endcase
			end
			// stride of the third digit, registered from the domain registers
			stride_c_q <= STRIDE_W'(dom_q[0]) * STRIDE_W'(dom_q[1]);
		end
	end

	// handshake chain through the three stages
	assign adv3     = valid_s3 && job_ready;
	assign ld3      = !valid_s3 || adv3;
	assign adv2     = valid_s2 && ld3;
	assign ld2      = !valid_s2 || ld3;
	assign adv1     = valid_s1 && ld2;
	assign in_ready = !hold && (!valid_s1 || ld2);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv2) begin
				valid_s3 <= 1'b1;
			end else if (adv3) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	// active digit count, clamped to the supported range
	always_comb begin
		used_n = active_q;
		if (used_n == '0) begin
			used_n = ACT_W'(1);
		end
		if (used_n > VAR_LIM_L) begin
			used_n = VAR_LIM_L;
		end
		for (int i = 0; i < MAX_DIGITS; i++) begin
			en_w[i] = ACT_W'(i) < used_n;
		end
	end

	// domain check and digit products
	always_comb begin
		bad_w = 1'b0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			dig_w[i] = en_w[i] ? DOM_W'(val_s1[i]) : '0;
			if (en_w[i] && (CMP_W'(val_s1[i]) >= CMP_W'(dom_q[i]))) begin
				bad_w = 1'b1;
			end
		end
	end

	assign pb_w   = STRIDE_W'(dig_w[1]) * STRIDE_W'(dom_q[0]);
	assign pc_w   = PART_W'(dig_w[2]) * PART_W'(stride_c_q);
	assign pdx_w  = PART_W'(dig_w[3]) * PART_W'(stride_c_q);
	assign pabc_w = IDX_W'(dig_w[0]) + IDX_W'(pb_w) + IDX_W'(pc_w);

	// last digit gets its third stride factor here
	assign idx_w  = pabc_s2 + IDX_W'(pdx_s2) * IDX_W'(dom_q[2]);

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1   <= req_type;
			val_s1[0] <= value_a;
			val_s1[1] <= value_b;
			val_s1[2] <= value_c;
			val_s1[3] <= value_d;
			weight_s1 <= row_weight;
			ridx_s1   <= read_index;
		end
		if (adv1) begin
			type_s2   <= type_s1;
			bad_s2    <= bad_w;
			pabc_s2   <= pabc_w;
			pdx_s2    <= pdx_w;
			weight_s2 <= weight_s1;
			ridx_s2   <= ridx_s1;
		end
		if (adv2) begin
			type_s3   <= type_s2;
			bad_s3    <= bad_s2;
			idx_s3    <= idx_w;
			weight_s3 <= weight_s2;
			ridx_s3   <= ridx_s2;
		end
	end

	// classify into a memory job or an immediate reply
	always_comb begin
		job.weight = weight_s3;
		if (type_s3 == REQ_READ) begin
			job.index = IDX_W'(ridx_s3);
			if ((IDX_W + 1)'(ridx_s3) < DEPTH_L) begin
				job.op     = JOB_READ;
				job.status = ST_OK;
			end else begin
				job.op     = JOB_REPLY;
				job.status = ST_RANGE;
			end
		end else if (bad_s3) begin
			job.op     = JOB_REPLY;
			job.index  = '0;
			job.status = ST_DOMAIN;
		end else if ({1'b0, idx_s3} < DEPTH_L) begin
			job.op     = JOB_COUNT;
			job.index  = idx_s3;
			job.status = ST_OK;
		end else begin
			job.op     = JOB_REPLY;
			job.index  = idx_s3;
			job.status = ST_RANGE;
		end
	end

	assign job_valid = valid_s3;

endmodule

`default_nettype wire

### design/wcc_queue.sv
// short job queue between the front end and the table update unit
`default_nettype none

module wcc_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  wcc_pkg::job_t push_data,
	output logic          pop_valid,
	input  wire logic     pop,
	output wcc_pkg::job_t pop_data
);
	import wcc_pkg::*;

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign push_ready = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### design/wcc_back.sv
// table update unit: count memory, clearing pass, read-modify-write and result register
`default_nettype none

module wcc_back #(
	parameter int TABLE_DEPTH = 65536,
	parameter int COUNT_BITS  = 48
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             job_valid,
	output logic                                  job_pop,
	input  wcc_pkg::job_t                         job,
	output logic                                  clearing,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [wcc_pkg::OUT_COUNT_W-1:0]       count_value,
	output logic [wcc_pkg::OUT_IDX_W-1:0]         entry_index,
	output logic [1:0]                            status
);
	import wcc_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam logic [ADDR_W-1:0]     CLR_LAST  = ADDR_W'(TABLE_DEPTH - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] mem [TABLE_DEPTH];
	logic [COUNT_BITS-1:0] rdata_q;

	back_state_t           state_q, state_d;
	logic [ADDR_W-1:0]     clr_q;
	job_t                  cur_q;

	logic                  out_valid_q;
	logic [OUT_COUNT_W-1:0] out_count_q;
	logic [OUT_IDX_W-1:0]  out_index_q;
	status_t               out_status_q;

	logic                  out_free;
	logic                  mem_we, mem_re, cur_load, out_load;
	logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
	logic [COUNT_BITS-1:0] mem_wdata, load_count;
	logic [IDX_W-1:0]      load_index;
	status_t               load_status;
	logic [COUNT_BITS:0]   sum_w;

	assign out_free  = !out_valid_q || out_ready;
	assign mem_raddr = ADDR_W'(job.index);
	assign sum_w     = {1'b0, rdata_q} + (COUNT_BITS + 1)'(cur_q.weight);
	assign clearing  = state_q == BK_CLEAR;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (job_valid && out_free && job.op != JOB_REPLY) begin
					state_d = BK_MODIFY;
				end
			end
			BK_MODIFY: state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop     = 1'b0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		cur_load    = 1'b0;
		out_load    = 1'b0;
		mem_waddr   = clr_q;
		mem_wdata   = '0;
		load_count  = '0;
		load_index  = cur_q.index;
		load_status = ST_OK;
		case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
			end
			BK_IDLE: begin
				if (job_valid && out_free) begin
					job_pop = 1'b1;
					if (job.op == JOB_REPLY) begin
						out_load    = 1'b1;
						load_index  = job.index;
						load_status = job.status;
					end else begin
						mem_re   = 1'b1;
						cur_load = 1'b1;
					end
				end
			end
			BK_MODIFY: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(cur_q.index);
				out_load  = 1'b1;
				if (cur_q.op == JOB_COUNT) begin
					if (sum_w[COUNT_BITS]) begin
						mem_wdata   = COUNT_MAX;
						load_status = ST_SAT;
					end else begin
						mem_wdata = sum_w[COUNT_BITS-1:0];
					end
					load_count = mem_wdata;
				end else begin
					// read request: return the old count, leave zero behind
					load_count = rdata_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cur_load) begin
			cur_q <= job;
		end
		if (out_load) begin
			out_count_q  <= OUT_COUNT_W'(load_count);
			out_index_q  <= OUT_IDX_W'(load_index);
			out_status_q <= load_status;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	assign out_valid   = out_valid_q;
	assign count_value = out_count_q;
	assign entry_index = out_index_q;
	assign status      = out_status_q;

	a_modify_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_MODIFY |-> !out_valid_q)
		else $error("update cycle found the result register occupied");

	a_job_to_modify: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_IDLE && job_pop && job.op != JOB_REPLY) |=> state_q == BK_MODIFY)
		else $error("memory job popped without an update cycle");

	a_domain_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_DOMAIN) |-> (out_count_q == '0 && out_index_q == '0))
		else $error("out-of-domain reply carries nonzero count or index");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_IDLE && $past(state_q) == BK_CLEAR) |-> $past(clr_q) == CLR_LAST)
		else $error("clearing pass left before the last entry");

endmodule

`default_nettype wire

### design/weighted_contingency_counter_unit.sv
// Weighted contingency counter: adds Q8.8 row weights into a Q40.8 count table at a
// mixed-radix index (first variable fastest) and answers read-and-clear requests.
// After reset all TABLE_DEPTH entries (65536 by default) are cleared one entry per cycle,
// with in_ready low; configuration writes are taken meanwhile. Each request
// runs through a three-stage front end (capture, domain check and digit products, index
// sum and classification) into a four-entry queue. The table update unit then handles
// a count or read request as a registered read of the single count memory, then add or
// clear and write back, and loads a request rejected as out of domain or beyond the
// table straight into the result register; it takes no new request from the queue
// until the write-back of a table access is done.
`default_nettype none

module weighted_contingency_counter_unit #(
	parameter int MAX_VARS    = 4,
	parameter int VALUE_BITS  = 4,
	parameter int TABLE_DEPTH = 65536,
	parameter int COUNT_BITS  = 48
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [wcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wcc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             req_type,
	input  wire logic [VALUE_BITS-1:0]            value_a,
	input  wire logic [VALUE_BITS-1:0]            value_b,
	input  wire logic [VALUE_BITS-1:0]            value_c,
	input  wire logic [VALUE_BITS-1:0]            value_d,
	input  wire logic [wcc_pkg::WEIGHT_W-1:0]     row_weight,
	input  wire logic [wcc_pkg::RIDX_W-1:0]       read_index,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [wcc_pkg::OUT_COUNT_W-1:0]       count_value,
	output logic [wcc_pkg::OUT_IDX_W-1:0]         entry_index,
	output logic [1:0]                            status
);
	import wcc_pkg::*;

	logic job_valid, job_ready, q_valid, q_pop, clearing;
	job_t job, q_job;

	wcc_front #(
		.MAX_VARS    (MAX_VARS),
		.VALUE_BITS  (VALUE_BITS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.value_a    (value_a),
		.value_b    (value_b),
		.value_c    (value_c),
		.value_d    (value_d),
		.row_weight (row_weight),
		.read_index (read_index),
		.hold       (clearing),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job)
	);

	wcc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_valid),
		.push_ready (job_ready),
		.push_data  (job),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_job)
	);

	wcc_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (q_valid),
		.job_pop     (q_pop),
		.job         (q_job),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.count_value (count_value),
		.entry_index (entry_index),
		.status      (status)
	);

endmodule

`default_nettype wire
